@@ design/dcbp_pkg.sv @@
`default_nettype none

package dcbp_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int BODY_DEPTH_DEF = 256;
    localparam int MAX_ARGS_DEF   = 8;
    localparam int MAX_SUFFIX_DEF = 8;

    // Fixed field widths of the interface.
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;
    localparam int ARGNUM_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int SUFPOS_W   = 4;
    localparam int SUFFIX_MAX = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_BYTE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DELIMITER_BYTE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ARGS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SUFFIX_BYTES   = 3'd4;

    typedef enum logic [1:0] {
        PH_WAIT    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_SUFFIX  = 2'd2
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT  = 3'd0,
        ST_PAYLOAD = 3'd1,
        ST_SEP     = 3'd2,
        ST_DONE    = 3'd3,
        ST_ERROR   = 3'd4,
        ST_ENDED   = 3'd5
    } status_t;

    typedef logic [SUFFIX_MAX-1:0][BYTE_W-1:0] suffix_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   start_byte;
        logic [BYTE_W-1:0]   delimiter_byte;
        logic [ARGNUM_W-1:0] expected_args;
        logic [SUFPOS_W-1:0] suffix_len;
        suffix_t             suffix_bytes;
    } cfg_t;

    typedef struct packed {
        status_t             status;
        logic [BYTE_W-1:0]   char_value;
        logic [BYTE_W-1:0]   char_index;
        logic [ARGNUM_W-1:0] arg_number;
    } result_t;

endpackage

`default_nettype wire

@@ design/dcbp_cfg.sv @@
`default_nettype none

// Configuration registers. The suffix length is held already clamped to
// the range 1 to MAX_SUFFIX, so the parser never has to clamp it.
module dcbp_cfg #(
    parameter int MAX_SUFFIX = dcbp_pkg::MAX_SUFFIX_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [dcbp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dcbp_pkg::CFG_DATA_W-1:0]     cfg_data,
    output dcbp_pkg::cfg_t                           cfg
);

    dcbp_pkg::cfg_t                      cfg_reg;
    dcbp_pkg::cfg_t                      cfg_next;
    logic [dcbp_pkg::SUFPOS_W-1:0]       len_raw;
    logic [dcbp_pkg::SUFPOS_W-1:0]       len_clamped;

    assign len_raw = cfg_data[dcbp_pkg::SUFPOS_W-1:0];

    always_comb
    begin
        if (len_raw == '0)
        begin
            len_clamped = dcbp_pkg::SUFPOS_W'(1);
        end
        else if (len_raw > dcbp_pkg::SUFPOS_W'(MAX_SUFFIX))
        begin
            len_clamped = dcbp_pkg::SUFPOS_W'(MAX_SUFFIX);
        end
        else
        begin
            len_clamped = len_raw;
        end
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                dcbp_pkg::CFG_START_BYTE:
                    cfg_next.start_byte = cfg_data[dcbp_pkg::BYTE_W-1:0];
                dcbp_pkg::CFG_DELIMITER_BYTE:
                    cfg_next.delimiter_byte = cfg_data[dcbp_pkg::BYTE_W-1:0];
                dcbp_pkg::CFG_EXPECTED_ARGS:
                    cfg_next.expected_args = cfg_data[dcbp_pkg::ARGNUM_W-1:0];
                dcbp_pkg::CFG_SUFFIX_LENGTH:
                    cfg_next.suffix_len = len_clamped;
                dcbp_pkg::CFG_SUFFIX_BYTES:
                    cfg_next.suffix_bytes = cfg_data;
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_byte     <= 8'd0;
            cfg_reg.delimiter_byte <= 8'd44;
            cfg_reg.expected_args  <= 4'd1;
            cfg_reg.suffix_len     <= 4'd1;
            cfg_reg.suffix_bytes   <= 64'd10;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/dcbp_core.sv @@
`default_nettype none

// Parser state and result register. One byte is consumed whenever the
// result register is free or being emptied in the same cycle.
module dcbp_core #(
    parameter int BODY_DEPTH = dcbp_pkg::BODY_DEPTH_DEF,
    parameter int MAX_ARGS   = dcbp_pkg::MAX_ARGS_DEF,
    parameter int MAX_SUFFIX = dcbp_pkg::MAX_SUFFIX_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dcbp_pkg::cfg_t                cfg,
    input  wire logic                          byte_valid,
    input  wire logic [dcbp_pkg::BYTE_W-1:0]   byte_data,
    output logic                               byte_take,
    output logic                               res_valid,
    input  wire logic                          res_stall,
    output dcbp_pkg::result_t                  res
);

    localparam int PW = $clog2(BODY_DEPTH) + 1;
    localparam int AW = $clog2(MAX_ARGS + 1);

    dcbp_pkg::phase_t                 phase_reg;
    dcbp_pkg::phase_t                 phase_next;
    logic [PW-1:0]                    pos_reg;
    logic [PW-1:0]                    pos_next;
    logic [AW-1:0]                    args_reg;
    logic [AW-1:0]                    args_next;
    logic [dcbp_pkg::SUFPOS_W-1:0]    suf_reg;
    logic [dcbp_pkg::SUFPOS_W-1:0]    suf_next;
    logic [dcbp_pkg::SUFPOS_W-1:0]    suf_inc;
    logic                             valid_reg;
    dcbp_pkg::result_t                res_reg;
    dcbp_pkg::result_t                res_next;

    logic                             advance;
    logic                             is_sfx0;
    logic                             is_delim;
    logic                             is_start;
    logic                             pos_full;
    logic                             args_match;
    logic                             args_max;
    logic                             len_one;
    logic                             sfx_bad;
    logic                             sfx_last;
    logic [PW+7:0]                    pos_wide;
    logic [AW+3:0]                    args_wide;
    logic [AW+3:0]                    args_inc_wide;
    logic [AW+3:0]                    exp_wide;
    logic [7:0]                       pos_idx;
    logic [3:0]                       args_out;
    logic [3:0]                       args_inc_out;

    assign byte_take = byte_valid && (!valid_reg || !res_stall);
    assign advance   = byte_take;

    assign suf_inc       = suf_reg + 1'b1;
    assign pos_wide      = {8'd0, pos_reg};
    assign args_wide     = {4'd0, args_reg};
    assign args_inc_wide = {4'd0, args_reg + 1'b1};
    assign exp_wide      = {{AW{1'b0}}, cfg.expected_args};
    assign pos_idx       = pos_wide[7:0];
    assign args_out      = args_wide[3:0];
    assign args_inc_out  = args_inc_wide[3:0];

    assign is_sfx0    = byte_data == cfg.suffix_bytes[0];
    assign is_delim   = byte_data == cfg.delimiter_byte;
    assign is_start   = byte_data == cfg.start_byte;
    assign pos_full   = pos_reg >= PW'(BODY_DEPTH);
    assign args_match = args_wide == exp_wide;
    assign args_max   = args_reg >= AW'(MAX_ARGS);
    assign len_one    = cfg.suffix_len == dcbp_pkg::SUFPOS_W'(1);
    assign sfx_bad    = (suf_reg >= dcbp_pkg::SUFPOS_W'(MAX_SUFFIX))
                        || (byte_data != cfg.suffix_bytes[suf_reg[2:0]]);
    assign sfx_last   = suf_inc >= cfg.suffix_len;

    // Next state of the parser.
    always_comb
    begin
        phase_next = dcbp_pkg::PH_WAIT;
        pos_next   = '0;
        args_next  = '0;
        suf_next   = dcbp_pkg::SUFPOS_W'(1);
        unique case (phase_reg)
            dcbp_pkg::PH_PAYLOAD:
            begin
                if (is_sfx0)
                begin
                    if (args_match && !pos_full && !len_one)
                    begin
                        phase_next = dcbp_pkg::PH_SUFFIX;
                        pos_next   = pos_reg;
                        args_next  = args_reg;
                    end
                end
                else if (!pos_full && !(is_delim && args_max))
                begin
                    phase_next = dcbp_pkg::PH_PAYLOAD;
                    pos_next   = pos_reg + 1'b1;
                    args_next  = is_delim ? args_reg + 1'b1 : args_reg;
                end
            end
            dcbp_pkg::PH_SUFFIX:
            begin
                if (!sfx_bad && !sfx_last)
                begin
                    phase_next = dcbp_pkg::PH_SUFFIX;
                    pos_next   = pos_reg;
                    args_next  = args_reg;
                    suf_next   = suf_inc;
                end
            end
            default:
            begin
                if (is_start)
                begin
                    phase_next = dcbp_pkg::PH_PAYLOAD;
                    args_next  = AW'(1);
                end
            end
        endcase
    end

    // Result for the byte being consumed.
    always_comb
    begin
        res_next = '{status: dcbp_pkg::ST_ERROR, char_value: '0,
                     char_index: '0, arg_number: '0};
        unique case (phase_reg)
            dcbp_pkg::PH_PAYLOAD:
            begin
                if (is_sfx0)
                begin
                    if (args_match && !pos_full)
                    begin
                        res_next.status     = len_one ? dcbp_pkg::ST_DONE
                                                      : dcbp_pkg::ST_ENDED;
                        res_next.char_index = pos_idx;
                        res_next.arg_number = args_out;
                    end
                end
                else if (!pos_full)
                begin
                    if (is_delim)
                    begin
                        if (!args_max)
                        begin
                            res_next.status     = dcbp_pkg::ST_SEP;
                            res_next.char_index = pos_idx;
                            res_next.arg_number = args_inc_out;
                        end
                    end
                    else
                    begin
                        res_next.status     = dcbp_pkg::ST_PAYLOAD;
                        res_next.char_value = byte_data;
                        res_next.char_index = pos_idx;
                        res_next.arg_number = args_out;
                    end
                end
            end
            dcbp_pkg::PH_SUFFIX:
            begin
                if (!sfx_bad)
                begin
                    res_next.status     = sfx_last ? dcbp_pkg::ST_DONE
                                                   : dcbp_pkg::ST_ACCEPT;
                    res_next.char_index = pos_idx;
                    res_next.arg_number = args_out;
                end
            end
            default:
            begin
                if (is_start)
                begin
                    res_next.status     = dcbp_pkg::ST_ACCEPT;
                    res_next.arg_number = 4'd1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= dcbp_pkg::PH_WAIT;
            pos_reg   <= '0;
            args_reg  <= '0;
            suf_reg   <= dcbp_pkg::SUFPOS_W'(1);
            valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                args_reg  <= args_next;
                suf_reg   <= suf_next;
                valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_error_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_reg.status == dcbp_pkg::ST_ERROR)
        |-> (res_reg.char_value == '0 && res_reg.char_index == '0
             && res_reg.arg_number == '0))
        else $error("error result carries non-zero fields");

    a_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (res_next.status == dcbp_pkg::ST_ERROR
                     || res_next.status == dcbp_pkg::ST_DONE))
        |=> (phase_reg == dcbp_pkg::PH_WAIT && pos_reg == '0 && args_reg == '0))
        else $error("parser not restarted after error or completion");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= PW'(BODY_DEPTH))
        else $error("body position beyond body depth");

    a_wait_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == dcbp_pkg::PH_WAIT)
        |-> (pos_reg == '0 && args_reg == '0 && suf_reg == dcbp_pkg::SUFPOS_W'(1)))
        else $error("state not cleared while waiting for start byte");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && res_stall) |=> (valid_reg && $stable(res_reg)
                                      && $stable(phase_reg)))
        else $error("result or state changed while output stalled");
`endif

endmodule

`default_nettype wire

@@ design/delimited_command_body_parser.sv @@
`default_nettype none

// Channel  Direction  Handshake               Payload
// -------  ---------  ----------------------  ------------------------------------------
// input    in         in_valid / in_stall     rx_byte
// output   out        out_valid / out_stall   status, char_value, char_index, arg_number
// config   in         cfg_write (no wait)     cfg_index, cfg_data
//
// One byte is taken every cycle while the output is not stalled, as the parser updates its
// whole state as it consumes each byte; each result moves out from the result register.
// Reset is asynchronous and active low: the parser waits for the start byte and the config
// registers take their defaults. There is no clearing pass.
// A stall on the output holds the result register; the input register takes at most
// one more transfer, and the input then stalls until the output moves again.
module delimited_command_body_parser #(
    parameter int BODY_DEPTH = dcbp_pkg::BODY_DEPTH_DEF,
    parameter int MAX_ARGS   = dcbp_pkg::MAX_ARGS_DEF,
    parameter int MAX_SUFFIX = dcbp_pkg::MAX_SUFFIX_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Configuration write port.
    input  wire logic                              cfg_write,
    input  wire logic [dcbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dcbp_pkg::CFG_DATA_W-1:0]   cfg_data,
    // Received bytes.
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [dcbp_pkg::BYTE_W-1:0]       rx_byte,
    // Status results.
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [dcbp_pkg::STATUS_W-1:0]          status,
    output logic [dcbp_pkg::BYTE_W-1:0]            char_value,
    output logic [dcbp_pkg::BYTE_W-1:0]            char_index,
    output logic [dcbp_pkg::ARGNUM_W-1:0]          arg_number
);

    dcbp_pkg::cfg_t                    cfg;
    dcbp_pkg::result_t                 res;

    // Input register: holds one byte until the parser consumes it.
    logic                              in_valid_reg;
    logic                              in_valid_next;
    logic [dcbp_pkg::BYTE_W-1:0]       in_byte_reg;
    logic                              in_take;
    logic                              core_take;

    // The input register is full and the parser cannot consume it this cycle.
    assign in_stall = in_valid_reg && !core_take;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next = in_take || (in_valid_reg && !core_take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= rx_byte;
        end
    end

    dcbp_cfg #(
        .MAX_SUFFIX (MAX_SUFFIX)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The parser updates its state and loads the result register in the
    // same cycle as it consumes the held byte.
    dcbp_core #(
        .BODY_DEPTH (BODY_DEPTH),
        .MAX_ARGS   (MAX_ARGS),
        .MAX_SUFFIX (MAX_SUFFIX)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .byte_valid (in_valid_reg),
        .byte_data  (in_byte_reg),
        .byte_take  (core_take),
        .res_valid  (out_valid),
        .res_stall  (out_stall),
        .res        (res)
    );

    assign status     = res.status;
    assign char_value = res.char_value;
    assign char_index = res.char_index;
    assign arg_number = res.arg_number;

endmodule

`default_nettype wire
